@@ rtl/core/spectral_band_power_noise_floor_unit_defines.svh @@
// assertion macros for the spectral band power unit
// included by the top level only; empty bodies when SYNTHESIS is set
`ifndef SPECTRAL_BAND_POWER_NOISE_FLOOR_UNIT_DEFINES_SVH
`define SPECTRAL_BAND_POWER_NOISE_FLOOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SBPNF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sbpnf: same-cycle check failed");
`define SBPNF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sbpnf: next-cycle check failed");
`else
`define SBPNF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SBPNF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/sbpnf_pkg.sv @@
// constants and types for the spectral band power unit
// no dependencies
package sbpnf_pkg;
    localparam int NUM_BANDS         = 4;
    localparam int FRAME_BINS        = 512;
    localparam int FRAMES_PER_REPORT = 8;
    localparam int SAMPLE_BITS       = 24;

    localparam int BAND_REGS  = 4;
    localparam int USED_BANDS = (NUM_BANDS < BAND_REGS) ? NUM_BANDS : BAND_REGS;
    localparam int BAND_W     = (USED_BANDS > 1) ? $clog2(USED_BANDS) : 1;
    localparam int HALF_BINS  = FRAME_BINS / 2;
    localparam int POS_W      = $clog2(HALF_BINS);
    localparam int FRM_W      = (FRAMES_PER_REPORT > 1) ? $clog2(FRAMES_PER_REPORT) : 1;
    localparam int CMP_W      = (POS_W > 9) ? POS_W : 9;
    localparam int MAG_W      = SAMPLE_BITS;
    localparam int PROD_W     = 2 * MAG_W + 1;
    localparam int SUM_W      = 60;
    localparam int AMP_W      = 29;
    localparam int FLOOR_W    = 45;
    localparam int RES_W      = 58;
    localparam int REFS_W     = AMP_W + 3;
    localparam int NUM_W      = REFS_W + 16;
    localparam int EMA_W      = 62;
    localparam int RPT_W      = 5;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 18;

    localparam logic [AMP_W-1:0]   AMP_MAX      = AMP_W'(268435456);
    localparam logic [SUM_W-1:0]   SUM_MAX      = '1;
    localparam logic [15:0]        ALPHA_Q16    = 16'd3277;
    localparam logic [15:0]        ONE_M_ALPHA  = 16'd62259;
    localparam logic [EMA_W-1:0]   ROUND_HALF   = EMA_W'(32768);
    localparam logic [RPT_W-1:0]   SETTLE_RPTS  = RPT_W'(20);
    localparam logic [4:0]         SQRT_STEPS   = 5'd28;
    localparam logic [4:0]         SQRT_LOAD    = 5'd29;
    localparam logic [5:0]         DIV_STEPS    = 6'(NUM_W - 1);

    localparam logic [IDX_W-1:0]   REG_MASK     = IDX_W'(BAND_REGS);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_SQRE = 10'b00_0000_0010,
        S_SQIM = 10'b00_0000_0100,
        S_ACC  = 10'b00_0000_1000,
        S_SQRT = 10'b00_0001_0000,
        S_DIV  = 10'b00_0010_0000,
        S_EMA1 = 10'b00_0100_0000,
        S_EMA2 = 10'b00_1000_0000,
        S_EMA3 = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } t_state;
endpackage

@@ rtl/core/spectral_band_power_noise_floor_unit.sv @@
// spectral band power accumulation with ema noise floor
// per bin: accept, square re, square im, accumulate; a report adds an isqrt per band,
// then a divide and the ema update (both skipped when no band is a reference),
// then 4 results at one per cycle as the sink takes them
// bins are taken one at a time while idle, set by the sequencer around the shared multiplier
// reset: synchronous active low, clears sums, counters, floor and registers
`include "spectral_band_power_noise_floor_unit_defines.svh"
module spectral_band_power_noise_floor_unit
    import sbpnf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [MAG_W-1:0] i_real_part,
    input  logic signed [MAG_W-1:0] i_imag_part,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_band_number,
    output logic [AMP_W-1:0]        o_amplitude,
    output logic [FLOOR_W-1:0]      o_floor_level,
    output logic                    o_floor_settled,
    output logic                    o_last_band,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);
    t_state r_state;
    logic [CFG_W-1:0]   r_range [BAND_REGS];
    logic [BAND_REGS-1:0] r_mask;
    logic [SUM_W-1:0]   r_sum [USED_BANDS];
    logic [AMP_W-1:0]   r_amp [USED_BANDS];
    logic [MAG_W-1:0]   r_re, r_im;
    logic [PROD_W-1:0]  r_prod;
    logic [POS_W-1:0]   r_pos;
    logic [FRM_W-1:0]   r_frame;
    logic [RPT_W-1:0]   r_rpt;
    logic [FLOOR_W-1:0] r_noise;
    logic [BAND_W-1:0]  r_band;
    logic [RES_W-1:0]   r_x, r_res;
    logic [4:0]         r_cnt;
    logic [5:0]         r_dcnt;
    logic [REFS_W-1:0]  r_refsum;
    logic [2:0]         r_refn;
    logic [NUM_W-1:0]   r_q;
    logic [2:0]         r_rem;
    logic [EMA_W-1:0]   r_ema;

    logic [MAG_W-1:0]     mag_re, mag_im, mul_a;
    logic [2*MAG_W-1:0]   sq;
    logic [USED_BANDS-1:0] hit;
    logic [RES_W-1:0]     bitv, trial;
    logic [RES_W-1:0]     n_res, n_x;
    logic [AMP_W-1:0]     amp_sat;
    logic [3:0]           dtry;
    logic [FLOOR_W-1:0]   ema_a;
    logic [15:0]          ema_b;
    logic [EMA_W-1:0]     ema_term;
    logic [SUM_W-1:0]     sum_sel;
    logic                 last_b;

    assign mag_re = i_real_part[MAG_W-1] ? MAG_W'(-i_real_part) : MAG_W'(i_real_part);
    assign mag_im = i_imag_part[MAG_W-1] ? MAG_W'(-i_imag_part) : MAG_W'(i_imag_part);

    // the one squaring multiplier, fed re then im
    assign mul_a = (r_state == S_SQRE) ? r_re : r_im;
    assign sq    = mul_a * mul_a;

    // first matching band only
    always_comb begin
        logic found;
        found = 1'b0;
        for (int j = 0; j < USED_BANDS; j++) begin
            hit[j] = 1'b0;
            if (!found && (CMP_W'(r_pos) >= CMP_W'(r_range[j][8:0]))
                    && (CMP_W'(r_pos) <= CMP_W'(r_range[j][17:9]))) begin
                hit[j] = 1'b1;
                found  = 1'b1;
            end
        end
    end

    // one isqrt step per cycle
    always_comb begin
        bitv  = RES_W'(1) << {r_cnt, 1'b0};
        trial = r_res + bitv;
        if (r_x >= trial) begin
            n_x   = r_x - trial;
            n_res = (r_res >> 1) + bitv;
        end else begin
            n_x   = r_x;
            n_res = r_res >> 1;
        end
        amp_sat = (n_res > RES_W'(AMP_MAX)) ? AMP_MAX : AMP_W'(n_res);
    end

    assign dtry     = {r_rem, r_q[NUM_W-1]};
    // one ema multiplier shared by the mean and floor terms
    assign ema_a    = (r_state == S_EMA1) ? r_q[FLOOR_W-1:0] : r_noise;
    assign ema_b    = (r_state == S_EMA1) ? ALPHA_Q16 : ONE_M_ALPHA;
    assign ema_term = EMA_W'(ema_a * ema_b);
    assign last_b   = (r_band == BAND_W'(USED_BANDS - 1));

    always_comb begin
        sum_sel = r_sum[0];
        for (int j = 0; j < USED_BANDS; j++) begin
            if (r_band == BAND_W'(j)) sum_sel = r_sum[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mask   <= '0;
            r_pos    <= '0;
            r_frame  <= '0;
            r_rpt    <= '0;
            r_noise  <= '0;
            r_band   <= '0;
            for (int j = 0; j < BAND_REGS; j++) r_range[j] <= '0;
            for (int j = 0; j < USED_BANDS; j++) r_sum[j] <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index < REG_MASK) r_range[i_cfg_index[1:0]] <= i_cfg_data;
                else if (i_cfg_index == REG_MASK) r_mask <= i_cfg_data[BAND_REGS-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_re    <= mag_re;
                        r_im    <= mag_im;
                        r_state <= S_SQRE;
                    end
                end
                S_SQRE: begin
                    r_prod  <= PROD_W'(sq);
                    r_state <= S_SQIM;
                end
                S_SQIM: begin
                    r_prod  <= r_prod + PROD_W'(sq);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    for (int j = 0; j < USED_BANDS; j++) begin
                        if (hit[j]) begin
                            logic [SUM_W:0] s;
                            s = {1'b0, r_sum[j]} + (SUM_W+1)'(r_prod);
                            r_sum[j] <= s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
                        end
                    end
                    if (r_pos == POS_W'(HALF_BINS - 1)) begin
                        r_pos <= '0;
                        if (r_frame == FRM_W'(FRAMES_PER_REPORT - 1)) begin
                            r_frame  <= '0;
                            r_band   <= '0;
                            r_refsum <= '0;
                            r_refn   <= '0;
                            r_state  <= S_SQRT;
                            r_cnt    <= SQRT_LOAD;
                        end else begin
                            r_frame <= r_frame + 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == SQRT_LOAD) begin
                        // first cycle of each band loads the operand
                        r_x   <= RES_W'(sum_sel / FRAMES_PER_REPORT);
                        r_res <= '0;
                        r_cnt <= SQRT_STEPS;
                    end else if (r_cnt != '0) begin
                        r_x   <= n_x;
                        r_res <= n_res;
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_amp[r_band] <= amp_sat;
                        if (r_mask[r_band]) begin
                            r_refsum <= r_refsum + REFS_W'(amp_sat);
                            r_refn   <= r_refn + 1'b1;
                        end
                        r_cnt <= SQRT_LOAD;
                        if (last_b) begin
                            r_state <= S_DIV;
                            r_dcnt  <= DIV_STEPS;
                            r_rem   <= '0;
                            r_q     <= {(r_mask[r_band] ? r_refsum + REFS_W'(amp_sat)
                                                        : r_refsum), 16'd0};
                        end else begin
                            r_band  <= r_band + 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    if (r_refn == '0) begin
                        r_state <= S_OUT;
                        r_band  <= '0;
                        if (r_rpt < SETTLE_RPTS) r_rpt <= r_rpt + 1'b1;
                    end else begin
                        if (dtry >= {1'b0, r_refn}) begin
                            r_rem <= 3'(dtry - {1'b0, r_refn});
                            r_q   <= {r_q[NUM_W-2:0], 1'b1};
                        end else begin
                            r_rem <= dtry[2:0];
                            r_q   <= {r_q[NUM_W-2:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt - 1'b1;
                        if (r_dcnt == '0) r_state <= S_EMA1;
                    end
                end
                S_EMA1: begin
                    r_ema   <= ema_term;
                    r_state <= S_EMA2;
                end
                S_EMA2: begin
                    r_ema   <= r_ema + ema_term + ROUND_HALF;
                    r_state <= S_EMA3;
                end
                S_EMA3: begin
                    r_noise <= r_ema[16 +: FLOOR_W];
                    r_band  <= '0;
                    r_state <= S_OUT;
                    if (r_rpt < SETTLE_RPTS) r_rpt <= r_rpt + 1'b1;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (last_b) begin
                            for (int j = 0; j < USED_BANDS; j++) r_sum[j] <= '0;
                            r_state <= S_IDLE;
                            r_band  <= '0;
                        end else begin
                            r_band <= r_band + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = (r_state == S_OUT);
    assign o_band_number   = 2'(r_band);
    assign o_amplitude     = r_amp[r_band];
    assign o_floor_level   = r_noise;
    assign o_floor_settled = (r_rpt >= SETTLE_RPTS);
    assign o_last_band     = last_b;

    `SBPNF_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, o_stall)
    `SBPNF_ASSERT_IMP(a_rpt_cap, i_clk, i_rst_n, 1'b1, r_rpt <= SETTLE_RPTS)
    `SBPNF_ASSERT_NXT(a_last_done, i_clk, i_rst_n, o_valid && !i_stall && o_last_band, !o_valid && !o_stall)
endmodule
